[hdl/lsa_pkg.sv]
// shared types, codes and sizes for the lifo stack allocator
package lsa_pkg;

	// default sizes
	localparam int unsigned MAX_BLOCKS_DEF   = 16;
	localparam int unsigned HEADER_BYTES_DEF = 8;

	// field widths
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned ALIGN_W  = 8;
	localparam int unsigned ADJ_W    = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned LIVE_W   = 5;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

	// configuration register indexes
	localparam logic REG_BASE_ADDRESS = 1'b0;
	localparam logic REG_TOTAL_SIZE   = 1'b1;

	// request transfer
	typedef struct packed {
		logic               cmd;
		logic [ADDR_W-1:0]  request_size;
		logic [ALIGN_W-1:0] align_bytes;
		logic [ADDR_W-1:0]  free_address;
	} lsa_req_t;

	// result transfer
	typedef struct packed {
		logic [ADDR_W-1:0]   block_address;
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   bytes_in_use;
		logic [LIVE_W-1:0]   live_blocks;
	} lsa_rsp_t;

	// per-block header kept in the cell row
	typedef struct packed {
		logic [ADDR_W-1:0] prev_block;
		logic [ADJ_W-1:0]  adjust;
	} lsa_entry_t;

	// shift control for the cell row
	typedef struct packed {
		logic push;
		logic pop;
	} lsa_stk_ctl_t;

endpackage

[hdl/lsa_cell.sv]
// one header cell of the stack: takes from the cell above on push, below on pop
module lsa_cell import lsa_pkg::*; (
	input  logic         clk,
	input  lsa_stk_ctl_t ctl,
	input  lsa_entry_t   from_above,
	input  lsa_entry_t   from_below,
	output lsa_entry_t   entry
);

	lsa_entry_t entry_q;

	// shift one place per push or pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

[hdl/lsa_stack.sv]
// row of header cells, cell zero holds the top block's header
module lsa_stack import lsa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic         clk,
	input  lsa_stk_ctl_t ctl,
	input  lsa_entry_t   push_entry,
	output lsa_entry_t   top_entry
);

	lsa_entry_t cells [MAX_BLOCKS];

	// chain the cells, the bottom one pulls in an empty header on pop
	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		lsa_entry_t above;
		lsa_entry_t below;

		if (i == 0) begin : g_first
			assign above = push_entry;
		end else begin : g_rest
			assign above = cells[i-1];
		end

		if (i == MAX_BLOCKS - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner
			assign below = cells[i+1];
		end

		lsa_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	assign top_entry = cells[0];

endmodule

[hdl/lifo_stack_allocator.sv]
// lifo stack allocator: one request at a time over a base/size region
// each request is latched, its alignment calculated, then it is committed;
// a new request is taken only when idle (busy low), not while one is in flight
// the receiver cannot stall; done is high for exactly one cycle per request
// reset clears the region registers, top, used count and block count at once;
// header cells are not cleared and are only read once written
module lifo_stack_allocator import lsa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              start,
	input  lsa_req_t          req,
	output logic              busy,
	output logic              done,
	output lsa_rsp_t          rsp
);

	localparam int unsigned      CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);
	localparam logic [ADJ_W-1:0] HDR = ADJ_W'(HEADER_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t            state_q;
	lsa_req_t          req_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] total_q;
	logic [ADDR_W-1:0] top_q;
	logic [ADDR_W-1:0] top_block_q;
	logic [ADDR_W-1:0] used_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	lsa_rsp_t          rsp_q;

	logic [ADJ_W-1:0]  adj_s1;
	logic [ADDR_W-1:0] remaining_s1;
	logic              match_s1;

	lsa_stk_ctl_t      stk_ctl;
	lsa_entry_t        push_entry;
	lsa_entry_t        top_entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			total_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_q  <= cfg_wdata;
				REG_TOTAL_SIZE:   total_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// alignment padding on the absolute top address
	logic [ADDR_W-1:0]  abs_top;
	logic [ALIGN_W-1:0] align_n;
	logic [ADJ_W-1:0]   mask;
	logic [ADJ_W-1:0]   misalign;
	logic [ADJ_W-1:0]   adj_base;
	logic [ADJ_W-1:0]   need;
	logic [ADJ_W-1:0]   adj_calc;
	logic [ADDR_W-1:0]  remaining_calc;

	always_comb begin
		abs_top = base_q + top_q;
		if (req_q.align_bytes != '0 &&
		    (req_q.align_bytes & (req_q.align_bytes - ALIGN_W'(1))) == '0) begin
			align_n = req_q.align_bytes;
		end else begin
			align_n = ALIGN_W'(1);
		end
		mask     = align_n - ADJ_W'(1);
		misalign = abs_top[ADJ_W-1:0] & mask;
		adj_base = (align_n - misalign) & mask;
		need     = HDR - adj_base;
		if (adj_base < HDR) begin
			adj_calc = adj_base + ((need + mask) & ~mask);
		end else begin
			adj_calc = adj_base;
		end
		remaining_calc = (used_q > total_q) ? '0 : total_q - used_q;
	end

	// commit decision
	logic [ADDR_W:0]     required;
	logic [ADDR_W-1:0]   blk_start;
	logic [ADDR_W-1:0]   pop_adj;
	logic [STATUS_W-1:0] status_c;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		required  = {1'b0, req_q.request_size} + (ADDR_W+1)'(adj_s1);
		blk_start = top_q + ADDR_W'(adj_s1);
		pop_adj   = ADDR_W'(top_entry.adjust);
		do_push   = 1'b0;
		do_pop    = 1'b0;
		if (req_q.cmd == CMD_ALLOC) begin
			if (req_q.request_size == '0) begin
				status_c = STATUS_ZERO_SIZE;
			end else if (required > {1'b0, remaining_s1}) begin
				status_c = STATUS_NO_ROOM;
			end else if (count_q >= CNT_FULL) begin
				status_c = STATUS_FULL;
			end else begin
				status_c = STATUS_OK;
				do_push  = 1'b1;
			end
		end else begin
			if (count_q == '0 || !match_s1) begin
				status_c = STATUS_BAD_FREE;
			end else begin
				status_c = STATUS_OK;
				do_pop   = 1'b1;
			end
		end
	end

	assign stk_ctl.push = (state_q == ST_COMMIT) && do_push;
	assign stk_ctl.pop  = (state_q == ST_COMMIT) && do_pop;
	assign push_entry.prev_block = top_block_q;
	assign push_entry.adjust     = adj_s1;

	lsa_stack #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_stack (
		.clk        (clk),
		.ctl        (stk_ctl),
		.push_entry (push_entry),
		.top_entry  (top_entry)
	);

	// sequencer, allocator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= '0;
			top_q        <= '0;
			top_block_q  <= '0;
			used_q       <= '0;
			count_q      <= '0;
			adj_s1       <= '0;
			remaining_s1 <= '0;
			match_s1     <= 1'b0;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			done_q <= (state_q == ST_COMMIT);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					adj_s1       <= adj_calc;
					remaining_s1 <= remaining_calc;
					match_s1     <= (req_q.free_address == base_q + top_block_q);
					state_q      <= ST_COMMIT;
				end
				ST_COMMIT: begin
					rsp_q.status <= status_c;
					if (do_push) begin
						top_block_q         <= blk_start;
						top_q               <= blk_start + req_q.request_size;
						used_q              <= used_q + required[ADDR_W-1:0];
						count_q             <= count_q + CNT_W'(1);
						rsp_q.block_address <= base_q + blk_start;
						rsp_q.bytes_in_use  <= used_q + required[ADDR_W-1:0];
						rsp_q.live_blocks   <= LIVE_W'(count_q + CNT_W'(1));
					end else if (do_pop) begin
						top_block_q         <= top_entry.prev_block;
						top_q               <= top_block_q - pop_adj;
						used_q              <= used_q - ((top_q - top_block_q) + pop_adj);
						count_q             <= count_q - CNT_W'(1);
						rsp_q.block_address <= '0;
						rsp_q.bytes_in_use  <= used_q - ((top_q - top_block_q) + pop_adj);
						rsp_q.live_blocks   <= LIVE_W'(count_q - CNT_W'(1));
					end else begin
						rsp_q.block_address <= '0;
						rsp_q.bytes_in_use  <= used_q;
						rsp_q.live_blocks   <= LIVE_W'(count_q);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hdl/lsa_checker.sv]
// port-level checks for the lifo stack allocator, bound to the top level
module lsa_checker import lsa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input lsa_req_t          req,
	input logic              busy,
	input logic              done,
	input lsa_rsp_t          rsp
);

	// a start transfer makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start transfer");

	// every start transfer yields its result strobe after calc and commit
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing after start transfer");

	// a result strobe is only shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a failed request hands out no address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STATUS_OK |-> rsp.block_address == '0)
		else $error("address given on failed request");

endmodule

bind lifo_stack_allocator lsa_checker u_lsa_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the lifo stack allocator
`timescale 1ns / 100ps

module testbench;
	import lsa_pkg::*;

	// allocator bookkeeping as seen from outside
	typedef struct {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] total;
		logic [ADDR_W-1:0] top;
		logic [ADDR_W-1:0] top_blk;
		logic [ADDR_W-1:0] used;
		logic [LIVE_W-1:0] live;
		lsa_entry_t        hdr [MAX_BLOCKS_DEF];
	} arena_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = REG_BASE_ADDRESS;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic              start     = 1'b0;
	lsa_req_t          req       = '0;
	logic              busy;
	logic              done;
	lsa_rsp_t          rsp;

	arena_t      arena_seen;  // advanced by accepted transfers
	arena_t      arena_plan;  // advanced as stimulus is generated
	lsa_req_t    req_backlog [$];
	lsa_rsp_t    rsp_due [$];
	bit          taken      = 1'b0;
	int unsigned gap_left   = 0;
	int unsigned burst_left = 0;
	int unsigned mismatches = 0;

	lifo_stack_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// one request against the bookkeeping, giving the result it should produce
	function automatic void apply_request(inout arena_t a, input lsa_req_t r,
			output lsa_rsp_t o);
		logic [ADDR_W-1:0] align, mask, adj, need, room, first;
		logic [ADDR_W:0]   charge;
		lsa_entry_t        entry;
		int unsigned       slot;
		o = '0;
		if (r.cmd == CMD_ALLOC) begin
			// bad alignment falls back to plain allocation
			align = 32'(r.align_bytes);
			if (align == 0 || (align & (align - 1)) != 0)
				align = 1;
			mask = align - 1;
			adj = (align - ((a.base + a.top) & mask)) & mask;
			if (adj < HEADER_BYTES_DEF) begin
				need = HEADER_BYTES_DEF - adj;
				adj += (need + mask) / align * align;
			end
			charge = {1'b0, r.request_size} + {1'b0, adj};
			room = (a.used > a.total) ? '0 : a.total - a.used;
			if (r.request_size == 0) begin
				o.status = STATUS_ZERO_SIZE;
			end else if (charge > {1'b0, room}) begin
				o.status = STATUS_NO_ROOM;
			end else if (32'(a.live) >= MAX_BLOCKS_DEF) begin
				o.status = STATUS_FULL;
			end else begin
				slot = 32'(a.live);
				a.hdr[slot].prev_block = a.top_blk;
				a.hdr[slot].adjust = adj[ADJ_W-1:0];
				a.live++;
				first = a.top + adj;
				a.top_blk = first;
				a.top = first + r.request_size;
				a.used += charge[ADDR_W-1:0];
				o.block_address = a.base + first;
				o.status = STATUS_OK;
			end
		end else if (a.live == 0 || r.free_address != a.base + a.top_blk) begin
			o.status = STATUS_BAD_FREE;
		end else begin
			// unwind the top block
			slot = 32'(a.live) - 1;
			entry = a.hdr[slot];
			a.used -= (a.top - a.top_blk) + 32'(entry.adjust);
			a.top = a.top_blk - 32'(entry.adjust);
			a.top_blk = entry.prev_block;
			a.live--;
			o.status = STATUS_OK;
		end
		o.bytes_in_use = a.used;
		o.live_blocks = a.live;
	endfunction

	// request driver: bursts of transfers with random gaps
	always @(negedge clk) begin : drive_requests
		logic next_start;
		next_start = start && !taken;
		if (!next_start) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (req_backlog.size() != 0) begin
				req <= req_backlog.pop_front();
				next_start = 1'b1;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
				end
			end
		end
		start <= next_start;
	end

	// result monitor and register write tracking
	always @(posedge clk) begin : watch_results
		lsa_rsp_t want;
		lsa_rsp_t due;
		if (arst_n) begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					due = rsp_due.pop_front();
					if (rsp.block_address !== due.block_address) begin
						$error("block_address: expected %h, got %h",
							due.block_address, rsp.block_address);
						mismatches++;
					end
					if (rsp.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, rsp.status);
						mismatches++;
					end
					if (rsp.bytes_in_use !== due.bytes_in_use) begin
						$error("bytes_in_use: expected %h, got %h",
							due.bytes_in_use, rsp.bytes_in_use);
						mismatches++;
					end
					if (rsp.live_blocks !== due.live_blocks) begin
						$error("live_blocks: expected %0d, got %0d",
							due.live_blocks, rsp.live_blocks);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_BASE_ADDRESS)
					arena_seen.base = cfg_wdata;
				else
					arena_seen.total = cfg_wdata;
			end
			if (start && !busy) begin
				apply_request(arena_seen, req, want);
				rsp_due = {rsp_due, want};
			end
		end
		taken <= arst_n && start && !busy;
	end

	task automatic write_reg(input logic index, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic plan_request(input logic cmd, input logic [ADDR_W-1:0] size,
			input logic [ALIGN_W-1:0] align, input logic [ADDR_W-1:0] addr);
		lsa_req_t r;
		lsa_rsp_t ignored;
		r.cmd = cmd;
		r.request_size = size;
		r.align_bytes = align;
		r.free_address = addr;
		apply_request(arena_plan, r, ignored);
		req_backlog = {req_backlog, r};
	endtask

	// mostly proper alloc/free sequences, drifting between filling and draining
	task automatic add_random(inout bit filling);
		logic               cmd;
		logic [ADDR_W-1:0]  size;
		logic [ADDR_W-1:0]  addr;
		logic [ALIGN_W-1:0] align;
		int unsigned        roll;
		if ($urandom_range(0, 11) == 0)
			filling = !filling;
		cmd = ($urandom_range(0, 9) < (filling ? 8 : 2)) ? CMD_ALLOC : CMD_FREE;
		roll = $urandom_range(0, 31);
		if (roll == 0)
			size = '0;
		else if (roll == 1)
			size = $urandom;
		else if (roll < 4)
			size = $urandom_range(1, 4096);
		else
			size = $urandom_range(1, 64);
		if ($urandom_range(0, 7) == 0)
			align = ALIGN_W'($urandom_range(1, 128));
		else
			align = 8'd1 << $urandom_range(0, 7);
		roll = $urandom_range(0, 9);
		addr = arena_plan.base + arena_plan.top_blk;
		if (roll == 0)
			addr = $urandom;
		else if (roll == 1)
			addr = addr ^ (32'd1 << $urandom_range(0, 31));
		plan_request(cmd, size, align, addr);
	endtask

	// wait until every request has been sent and answered
	task automatic settle();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || start || rsp_due.size() != 0);
	endtask

	task automatic run_phase(input int unsigned count, input bit fill_first);
		bit filling;
		filling = fill_first;
		arena_plan = arena_seen;
		repeat (count)
			add_random(filling);
		settle();
	endtask

	// reset, directed cases, then random phases over several region settings
	initial begin : stimulus
		arena_seen.base = '0;
		arena_seen.total = '0;
		arena_seen.top = '0;
		arena_seen.top_blk = '0;
		arena_seen.used = '0;
		arena_seen.live = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty region straight after reset
		arena_plan = arena_seen;
		plan_request(CMD_ALLOC, 32'd5, 8'd1, '0);
		plan_request(CMD_ALLOC, '0, 8'd1, '0);
		plan_request(CMD_FREE, 32'd7, 8'd2, '0);
		settle();

		// region wrapping past the top of the address space
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
		write_reg(REG_TOTAL_SIZE, 32'hFFFF_FFFF);
		arena_plan = arena_seen;
		plan_request(CMD_ALLOC, '0, 8'd128, '0);
		plan_request(CMD_ALLOC, 32'hFFFF_FFFF, 8'd128, '0);
		plan_request(CMD_ALLOC, 32'd1, 8'd1, '0);
		plan_request(CMD_ALLOC, 32'd3, 8'd3, '0);
		plan_request(CMD_ALLOC, 32'd17, 8'd0, '0);
		plan_request(CMD_ALLOC, 32'd40, 8'd128, '0);
		plan_request(CMD_FREE, '0, 8'd1, arena_plan.base + arena_plan.top_blk + 1);
		plan_request(CMD_FREE, '0, 8'd1, arena_plan.base + arena_plan.top_blk);
		// fill the header stack, then overflow it
		while (32'(arena_plan.live) < MAX_BLOCKS_DEF)
			plan_request(CMD_ALLOC, $urandom_range(1, 32), 8'd4, '0);
		plan_request(CMD_ALLOC, 32'd8, 8'd16, '0);
		plan_request(CMD_ALLOC, '0, 8'd16, '0);
		plan_request(CMD_ALLOC, 32'hFFFF_FFFF, 8'd1, '0);
		settle();

		// region shrunk below what is in use, then drained
		write_reg(REG_TOTAL_SIZE, arena_seen.used >> 1);
		run_phase(120, 1'b0);
		write_reg(REG_BASE_ADDRESS, '0);
		write_reg(REG_TOTAL_SIZE, 32'hFFFF_FFFF);
		run_phase(200, 1'b1);
		write_reg(REG_BASE_ADDRESS, $urandom);
		write_reg(REG_TOTAL_SIZE, 32'd4096);
		run_phase(200, 1'b1);
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
		write_reg(REG_TOTAL_SIZE, 32'd1500);
		run_phase(150, 1'b1);
		write_reg(REG_TOTAL_SIZE, '0);
		run_phase(60, 1'b0);
		write_reg(REG_BASE_ADDRESS, $urandom);
		write_reg(REG_TOTAL_SIZE, $urandom);
		run_phase(200, 1'b1);
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FF80);
		write_reg(REG_TOTAL_SIZE, 32'd600);
		run_phase(150, 1'b1);
		write_reg(REG_BASE_ADDRESS, $urandom);
		write_reg(REG_TOTAL_SIZE, $urandom_range(200, 100000));
		run_phase(120, 1'b1);

		// allow for any stray strobe after the last result
		repeat (8) @(posedge clk);
		if (mismatches == 0 && rsp_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
